/* design/legv8_subset_execute_macros.svh */
// Assertion macros for the execute block's top-level RTL file
`ifndef LEGV8_SUBSET_EXECUTE_MACROS_SVH
`define LEGV8_SUBSET_EXECUTE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, disabled in reset
`define LGX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, disabled in reset
`define LGX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lgx_pkg.sv */
// Package: operation codes, transfer payload types and defaults for the execute block
package lgx_pkg;

    localparam int NUM_REGS_DEF   = 32;
    localparam int MEM_WORDS_DEF  = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W     = 4;
    localparam int REG_IDX_W = 5;
    localparam int WORD_W    = 32;

    localparam logic signed [WORD_W-1:0] PC_STEP_SEQ = 32'sd1;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD  = 4'd0,
        OP_ADDI = 4'd1,
        OP_SUB  = 4'd2,
        OP_SUBI = 4'd3,
        OP_ORR  = 4'd4,
        OP_AND  = 4'd5,
        OP_LDUR = 4'd6,
        OP_STUR = 4'd7,
        OP_B    = 4'd8,
        OP_CBZ  = 4'd9
    } t_op;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [REG_IDX_W-1:0]      target_reg;
        logic [REG_IDX_W-1:0]      first_source_reg;
        logic [REG_IDX_W-1:0]      second_source_reg;
        logic signed [WORD_W-1:0]  immediate;
    } t_item;

    typedef struct packed {
        logic signed [WORD_W-1:0]  pc_step;
        logic                      reg_write_enable;
        logic [REG_IDX_W-1:0]      reg_write_index;
        logic signed [WORD_W-1:0]  reg_write_value;
        logic                      mem_write_enable;
        logic [REG_IDX_W-1:0]      mem_write_index;
        logic signed [WORD_W-1:0]  mem_write_value;
    } t_result;

    typedef struct packed {
        logic reg_we;
        logic is_load;
        logic mem_we;
        logic mem_ok;
    } t_exec_flags;

endpackage

/* design/lgx_regfile.sv */
// Register file memory: two registered read ports, one write port
module lgx_regfile #(
    parameter int NUM_REGS   = lgx_pkg::NUM_REGS_DEF,
    parameter int DATA_WIDTH = lgx_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [$clog2(NUM_REGS)-1:0] i_rd_addr_a,
    input  logic [$clog2(NUM_REGS)-1:0] i_rd_addr_b,
    output logic [DATA_WIDTH-1:0]       o_rd_data_a,
    output logic [DATA_WIDTH-1:0]       o_rd_data_b,
    input  logic                        i_wr_en,
    input  logic [$clog2(NUM_REGS)-1:0] i_wr_addr,
    input  logic [DATA_WIDTH-1:0]       i_wr_data
);
    import lgx_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [NUM_REGS];
    logic [DATA_WIDTH-1:0] r_rd_a;
    logic [DATA_WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

/* design/lgx_dmem.sv */
// Data memory: one registered read port, one write port
module lgx_dmem #(
    parameter int MEM_WORDS  = lgx_pkg::MEM_WORDS_DEF,
    parameter int DATA_WIDTH = lgx_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MEM_WORDS)-1:0] i_rd_addr,
    output logic [DATA_WIDTH-1:0]        o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(MEM_WORDS)-1:0] i_wr_addr,
    input  logic [DATA_WIDTH-1:0]        i_wr_data
);
    import lgx_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [MEM_WORDS];
    logic [DATA_WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

/* design/lgx_alu.sv */
// Execute logic: ALU result, word address and range check, branch step
module lgx_alu #(
    parameter int MEM_WORDS  = lgx_pkg::MEM_WORDS_DEF,
    parameter int DATA_WIDTH = lgx_pkg::DATA_WIDTH_DEF
) (
    input  logic [lgx_pkg::CMD_W-1:0]         i_cmd,
    input  logic                              i_rt_ok,
    input  logic [DATA_WIDTH-1:0]             i_a,
    input  logic [DATA_WIDTH-1:0]             i_b,
    input  logic signed [lgx_pkg::WORD_W-1:0] i_imm,
    output lgx_pkg::t_exec_flags              o_flags,
    output logic [DATA_WIDTH-1:0]             o_result,
    output logic [DATA_WIDTH-1:0]             o_addr,
    output logic signed [lgx_pkg::WORD_W-1:0] o_pc_step
);
    import lgx_pkg::*;

    localparam int MAW  = $clog2(MEM_WORDS);
    localparam int CMPW = (DATA_WIDTH > MAW + 1) ? DATA_WIDTH : MAW + 1;

    logic [DATA_WIDTH-1:0] imm_d;
    logic [DATA_WIDTH-1:0] addr;
    logic                  addr_ok;
    logic                  we;

    always_comb begin
        imm_d   = DATA_WIDTH'(i_imm);
        addr    = i_a + imm_d;
        addr_ok = !addr[DATA_WIDTH-1] && (CMPW'(addr) < CMPW'(MEM_WORDS));

        we        = 1'b0;
        o_result  = '0;
        o_pc_step = PC_STEP_SEQ;
        o_flags   = '0;

        case (i_cmd)
            OP_ADD: begin
                we       = 1'b1;
                o_result = i_a + i_b;
            end
            OP_ADDI: begin
                we       = 1'b1;
                o_result = i_a + imm_d;
            end
            OP_SUB: begin
                we       = 1'b1;
                o_result = i_a - i_b;
            end
            OP_SUBI: begin
                we       = 1'b1;
                o_result = i_a - imm_d;
            end
            OP_ORR: begin
                we       = 1'b1;
                o_result = i_a | i_b;
            end
            OP_AND: begin
                we       = 1'b1;
                o_result = i_a & i_b;
            end
            OP_LDUR: begin
                we              = 1'b1;
                o_flags.is_load = 1'b1;
            end
            OP_STUR: begin
                o_flags.mem_we = addr_ok;
            end
            OP_B: begin
                o_pc_step = i_imm;
            end
            OP_CBZ: begin
                if (i_b == '0) begin
                    o_pc_step = i_imm;
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase

        o_flags.reg_we = we && i_rt_ok;
        o_flags.mem_ok = addr_ok;
        o_addr         = addr;
    end

endmodule

/* design/legv8_subset_execute.sv */
// Top level: three-stage executor for a small LEGv8-style instruction subset
//
// Input channel i_in_valid / o_in_stall / i_in_data carries one decoded
// instruction per transfer; output channel o_out_valid / i_out_stall /
// o_out_data carries its result: register write, memory write, pc step.
// Stages: operand read (registered register-file ports, bypass from the
// two older writes), execute with data-memory read and store, then the
// result register. One instruction is taken every cycle while neither the
// output stall nor the clearing pass holds the input back.
// Reset clears the pipeline, then a clearing pass zeroes the register file
// and data memory, one word a cycle, over max(NUM_REGS, MEM_WORDS) words
// (32 by default) with o_in_stall high.
// When the receiver stalls, the result holds and empty stages still fill;
// o_in_stall rises once all three stages hold an item.
`include "legv8_subset_execute_macros.svh"

module legv8_subset_execute #(
    parameter int NUM_REGS   = lgx_pkg::NUM_REGS_DEF,
    parameter int MEM_WORDS  = lgx_pkg::MEM_WORDS_DEF,
    parameter int DATA_WIDTH = lgx_pkg::DATA_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  lgx_pkg::t_item   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output lgx_pkg::t_result o_out_data
);
    import lgx_pkg::*;

    localparam int RAW       = $clog2(NUM_REGS);
    localparam int MAW       = $clog2(MEM_WORDS);
    localparam int CLR_DEPTH = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;
    localparam int CLW       = $clog2(CLR_DEPTH);
    localparam int IDXCW     = REG_IDX_W + 1;

    function automatic logic reg_ok(input logic [REG_IDX_W-1:0] idx);
        reg_ok = {1'b0, idx} < IDXCW'(NUM_REGS);
    endfunction

    function automatic logic uses_rm(input logic [CMD_W-1:0] cmd);
        uses_rm = (cmd == OP_ADD) || (cmd == OP_SUB) || (cmd == OP_ORR) || (cmd == OP_AND);
    endfunction

    logic                  r_clr_busy;
    logic [CLW-1:0]        r_clr_idx;
    logic                  clr_rf_we;
    logic                  clr_dm_we;

    logic                  r_s1_v;
    t_item                 r_s1;
    logic                  r_s2_v;
    t_exec_flags           r_s2_flags;
    logic [REG_IDX_W-1:0]  r_s2_widx;
    logic [DATA_WIDTH-1:0] r_s2_val;
    logic signed [WORD_W-1:0] r_s2_pc;
    logic [REG_IDX_W-1:0]  r_s2_mem_idx;
    logic [DATA_WIDTH-1:0] r_s2_mem_val;
    logic                  r_out_v;
    t_result               r_out;

    logic                  r_lw_v;
    logic [REG_IDX_W-1:0]  r_lw_idx;
    logic [DATA_WIDTH-1:0] r_lw_val;

    logic                  adv_out;
    logic                  adv_s2;
    logic                  adv_s1;
    logic                  s1_take;

    logic [REG_IDX_W-1:0]  acc_b_idx;
    logic [REG_IDX_W-1:0]  s1_b_idx;
    logic [DATA_WIDTH-1:0] rf_a;
    logic [DATA_WIDTH-1:0] rf_b;
    logic [DATA_WIDTH-1:0] op_a;
    logic [DATA_WIDTH-1:0] op_b;

    t_exec_flags           ex_flags;
    logic [DATA_WIDTH-1:0] ex_result;
    logic [DATA_WIDTH-1:0] ex_addr;
    logic signed [WORD_W-1:0] ex_pc;

    logic [DATA_WIDTH-1:0] dm_q;
    logic [DATA_WIDTH-1:0] s2_wval;
    logic                  wb_we;
    t_result               n_out;

    logic                  rf_we;
    logic [RAW-1:0]        rf_waddr;
    logic [DATA_WIDTH-1:0] rf_wdata;
    logic                  dm_we;
    logic [MAW-1:0]        dm_waddr;
    logic [DATA_WIDTH-1:0] dm_wdata;

    // Stage flow
    assign adv_out    = !r_out_v || !i_out_stall;
    assign adv_s2     = !r_s2_v || adv_out;
    assign adv_s1     = !r_s1_v || adv_s2;
    assign s1_take    = adv_s1 && !r_clr_busy;
    assign o_in_stall = !adv_s1 || r_clr_busy;

    // Clearing pass
    assign clr_rf_we = r_clr_busy && ((CLW + 1)'(r_clr_idx) < (CLW + 1)'(NUM_REGS));
    assign clr_dm_we = r_clr_busy && ((CLW + 1)'(r_clr_idx) < (CLW + 1)'(MEM_WORDS));

    // Operand read and bypass
    assign acc_b_idx = uses_rm(i_in_data.cmd) ? i_in_data.second_source_reg
                                              : i_in_data.target_reg;
    assign s1_b_idx  = uses_rm(r_s1.cmd) ? r_s1.second_source_reg : r_s1.target_reg;

    assign s2_wval = r_s2_flags.is_load ? (r_s2_flags.mem_ok ? dm_q : '0) : r_s2_val;
    assign wb_we   = r_s2_v && adv_out && r_s2_flags.reg_we;

    function automatic logic [DATA_WIDTH-1:0] fwd_val(
        input logic [REG_IDX_W-1:0]  idx,
        input logic [DATA_WIDTH-1:0] rdata
    );
        if (!reg_ok(idx)) begin
            fwd_val = '0;
        end else if (r_s2_v && r_s2_flags.reg_we && (r_s2_widx == idx)) begin
            fwd_val = s2_wval;
        end else if (r_lw_v && (r_lw_idx == idx)) begin
            fwd_val = r_lw_val;
        end else begin
            fwd_val = rdata;
        end
    endfunction

    always_comb begin
        op_a = fwd_val(r_s1.first_source_reg, rf_a);
        op_b = fwd_val(s1_b_idx, rf_b);
    end

    // Memory write ports
    always_comb begin
        rf_we    = clr_rf_we || wb_we;
        rf_waddr = r_clr_busy ? r_clr_idx[RAW-1:0] : r_s2_widx[RAW-1:0];
        rf_wdata = r_clr_busy ? '0 : s2_wval;
        dm_we    = clr_dm_we || (r_s1_v && adv_s2 && ex_flags.mem_we);
        dm_waddr = r_clr_busy ? r_clr_idx[MAW-1:0] : ex_addr[MAW-1:0];
        dm_wdata = r_clr_busy ? '0 : op_b;
    end

    lgx_regfile #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rd_en     (s1_take),
        .i_rd_addr_a (i_in_data.first_source_reg[RAW-1:0]),
        .i_rd_addr_b (acc_b_idx[RAW-1:0]),
        .o_rd_data_a (rf_a),
        .o_rd_data_b (rf_b),
        .i_wr_en     (rf_we),
        .i_wr_addr   (rf_waddr),
        .i_wr_data   (rf_wdata)
    );

    lgx_alu #(
        .MEM_WORDS  (MEM_WORDS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .i_cmd     (r_s1.cmd),
        .i_rt_ok   (reg_ok(r_s1.target_reg)),
        .i_a       (op_a),
        .i_b       (op_b),
        .i_imm     (r_s1.immediate),
        .o_flags   (ex_flags),
        .o_result  (ex_result),
        .o_addr    (ex_addr),
        .o_pc_step (ex_pc)
    );

    lgx_dmem #(
        .MEM_WORDS  (MEM_WORDS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dmem (
        .i_clk     (i_clk),
        .i_rd_en   (adv_s2),
        .i_rd_addr (ex_addr[MAW-1:0]),
        .o_rd_data (dm_q),
        .i_wr_en   (dm_we),
        .i_wr_addr (dm_waddr),
        .i_wr_data (dm_wdata)
    );

    // Result formatting
    always_comb begin
        n_out                  = '0;
        n_out.pc_step          = r_s2_pc;
        n_out.reg_write_enable = r_s2_flags.reg_we;
        n_out.mem_write_enable = r_s2_flags.mem_we;
        if (r_s2_flags.reg_we) begin
            n_out.reg_write_index = r_s2_widx;
            n_out.reg_write_value = WORD_W'($signed(s2_wval));
        end
        if (r_s2_flags.mem_we) begin
            n_out.mem_write_index = r_s2_mem_idx;
            n_out.mem_write_value = WORD_W'($signed(r_s2_mem_val));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_lw_v     <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == CLW'(CLR_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (s1_take) begin
                r_s1_v <= i_in_valid;
            end else if (adv_s1) begin
                r_s1_v <= 1'b0;
            end
            if (adv_s2) begin
                r_s2_v <= r_s1_v;
            end
            if (adv_out) begin
                r_out_v <= r_s2_v;
            end
            if (wb_we) begin
                r_lw_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_s1 <= i_in_data;
        end
        if (adv_s2) begin
            r_s2_flags   <= ex_flags;
            r_s2_widx    <= r_s1.target_reg;
            r_s2_val     <= ex_result;
            r_s2_pc      <= ex_pc;
            r_s2_mem_idx <= ex_addr[REG_IDX_W-1:0];
            r_s2_mem_val <= op_b;
        end
        if (adv_out) begin
            r_out <= n_out;
        end
        if (wb_we) begin
            r_lw_idx <= r_s2_widx;
            r_lw_val <= s2_wval;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    `LGX_ASSERT_NOW(a_clr_no_take, r_clr_busy, o_in_stall, "transfer taken during clearing pass")
    `LGX_ASSERT_NOW(a_clr_empty, r_clr_busy, !r_s1_v && !r_s2_v && !r_out_v, "stage busy in clear")
    `LGX_ASSERT_NEXT(a_s1_hold, r_s1_v && !adv_s2, r_s1_v && $stable(r_s1), "operand stage lost")
    `LGX_ASSERT_NEXT(a_s2_to_out, r_s2_v && adv_out, r_out_v, "execute stage result dropped")

endmodule
